// ===== rtl/ssm_pkg.sv =====
// ssm_pkg: shared types and codes for the stream sub-array matcher
// used by ssm_cell and stream_subarray_match; no dependencies
`default_nettype none

package ssm_pkg;

    // opcode of an input transaction
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam int WORD_W = 32;
    localparam int POS_OUT_W = 16;
    localparam int CFG_W = 4;
    localparam int SLOT_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    // per-cycle control broadcast to one cell
    typedef struct packed {
        logic shift;
        logic load;
        logic active;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ssm_cell.sv =====
// ssm_cell: one cell of the matcher row, holds one window word and one pattern word
// depends on ssm_pkg
`default_nettype none

module ssm_cell
(
    input  wire logic               clk,
    input  wire ssm_pkg::cell_ctrl_t ctrl,
    input  wire ssm_pkg::word_t     win_in,
    input  wire ssm_pkg::word_t     pat_in,
    input  wire ssm_pkg::word_t     cmp_pat,
    output ssm_pkg::word_t          win_out,
    output ssm_pkg::word_t          pat_out,
    output logic                    hit
);

    ssm_pkg::word_t win_reg;
    ssm_pkg::word_t win_next;
    ssm_pkg::word_t pat_reg;
    ssm_pkg::word_t pat_next;

    always_comb
    begin
        win_next = ctrl.shift ? win_in : win_reg;
        pat_next = ctrl.load ? pat_in : pat_reg;
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        pat_reg <= pat_next;
    end

    // compare the word entering this cell against its pattern slot
    assign hit     = !ctrl.active || (win_in == cmp_pat);
    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

`default_nettype wire

// ===== rtl/stream_subarray_match.sv =====
// stream_subarray_match: first occurrence of a short word pattern in a text stream
// a result appears on the output register in the cycle after the text word is accepted
// throughput: one transaction per cycle; the row of compare cells checks every pattern word at once
// input stalls only while a result waits in the output register and the output is stalled
// reset: asynchronous active low; clears search state, length goes to 1, pattern cells keep
// whatever they hold until loaded; no clearing pass is needed
// depends on ssm_pkg and ssm_cell
`default_nettype none

module stream_subarray_match
#(
    parameter int PATTERN_MAX = 8,
    parameter int TEXT_MAX    = 65536
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ssm_pkg::CFG_W-1:0]             pattern_length,
    // input transaction channel
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic                                  op,
    input  wire logic [ssm_pkg::SLOT_W-1:0]            pattern_index,
    input  wire logic signed [ssm_pkg::WORD_W-1:0]     word,
    input  wire logic                                  last,
    // result transaction channel
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic                                       found,
    output logic [ssm_pkg::POS_OUT_W-1:0]              start_position
);

    // widths derived from the parameters
    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int CMP_W  = (LEN_W > ssm_pkg::CFG_W) ? LEN_W : ssm_pkg::CFG_W;
    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int IDX_W  = (PIDX_W > ssm_pkg::SLOT_W) ? PIDX_W : ssm_pkg::SLOT_W;
    localparam int CNT_W  = $clog2(TEXT_MAX + 1);
    localparam int POS_W  = (CNT_W > ssm_pkg::POS_OUT_W) ? CNT_W : ssm_pkg::POS_OUT_W;

    // search state
    logic [ssm_pkg::CFG_W-1:0] len_reg;
    logic [ssm_pkg::CFG_W-1:0] len_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      reported_reg;
    logic                      reported_next;

    // output register
    logic                          valid_reg;
    logic                          valid_next;
    logic                          found_reg;
    logic                          found_next;
    logic [ssm_pkg::POS_OUT_W-1:0] start_reg;
    logic [ssm_pkg::POS_OUT_W-1:0] start_next;

    logic              accept;
    logic              is_text;
    logic              advance;
    logic              match;
    logic [CMP_W-1:0]  len_wide;
    logic [CMP_W-1:0]  len_clamp;
    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  count_inc;
    logic [POS_W-1:0]  pos_wide;

    ssm_pkg::cell_ctrl_t ctrl      [PATTERN_MAX];
    ssm_pkg::word_t      win_in    [PATTERN_MAX];
    ssm_pkg::word_t      win_out   [PATTERN_MAX];
    ssm_pkg::word_t      pat_out   [PATTERN_MAX];
    ssm_pkg::word_t      cmp_pat   [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    // handshakes: hold off new words only while a result is stuck in the output register
    assign cfg_ready  = 1'b1;
    assign item_stall = valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign is_text    = (op == ssm_pkg::OP_TEXT);

    // effective pattern length: zero acts as one, clamp to the cell count
    always_comb
    begin
        len_wide = CMP_W'(len_reg);
        priority if (len_wide == '0)
        begin
            len_clamp = CMP_W'(1);
        end
        else if (len_wide > CMP_W'(PATTERN_MAX))
        begin
            len_clamp = CMP_W'(PATTERN_MAX);
        end
        else
        begin
            len_clamp = len_wide;
        end
        len_eff = LEN_W'(len_clamp);
    end

    // a text word enters the window while no match is reported and the text still fits
    assign advance   = accept && is_text && !reported_reg
                       && (count_reg < CNT_W'(TEXT_MAX));
    assign count_inc = count_reg + CNT_W'(1);

    // row of cells: the newest word enters cell 0 and ages one cell per text word
    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        logic [LEN_W-1:0] sel;

        assign ctrl[j].shift  = advance;
        assign ctrl[j].load   = accept && !is_text
                                && (IDX_W'(pattern_index) == IDX_W'(j));
        assign ctrl[j].active = (LEN_W'(j) < len_eff);

        if (j == 0)
        begin : g_head
            assign win_in[j] = word;
        end
        else
        begin : g_link
            assign win_in[j] = win_out[j-1];
        end

        // window age j lines up with pattern slot len-1-j
        assign sel = len_eff - LEN_W'(1) - LEN_W'(j);
        assign cmp_pat[j] = ctrl[j].active ? pat_out[PIDX_W'(sel)] : '0;

        ssm_cell u_cell
        (
            .clk     (clk),
            .ctrl    (ctrl[j]),
            .win_in  (win_in[j]),
            .pat_in  (word),
            .cmp_pat (cmp_pat[j]),
            .win_out (win_out[j]),
            .pat_out (pat_out[j]),
            .hit     (cell_hit[j])
        );
    end

    // full match once enough words are in and every active cell agrees
    assign match    = advance && (POS_W'(count_inc) >= POS_W'(len_eff)) && (&cell_hit);
    assign pos_wide = POS_W'(count_inc) - POS_W'(len_eff);

    always_comb
    begin
        len_next      = len_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        valid_next    = valid_reg && result_stall;
        found_next    = found_reg;
        start_next    = start_reg;

        if (cfg_valid && cfg_ready)
        begin
            len_next = pattern_length;
        end

        if (advance)
        begin
            count_next = count_inc;
        end

        if (match)
        begin
            reported_next = 1'b1;
            valid_next    = 1'b1;
            found_next    = 1'b1;
            start_next    = pos_wide[ssm_pkg::POS_OUT_W-1:0];
        end

        // end of the searched array: report a miss if nothing was found, then start over
        if (accept && is_text && last)
        begin
            if (!reported_reg && !match)
            begin
                valid_next = 1'b1;
                found_next = 1'b0;
                start_next = '0;
            end
            count_next    = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= ssm_pkg::CFG_W'(1);
            count_reg    <= '0;
            reported_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            count_reg    <= count_next;
            reported_reg <= reported_next;
            valid_reg    <= valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        start_reg <= start_next;
    end

    assign result_valid   = valid_reg;
    assign found          = found_reg;
    assign start_position = start_reg;

endmodule

`default_nettype wire

// ===== rtl/ssm_checker.sv =====
// ssm_checker: port-level assertions for stream_subarray_match, bound to the top level
// depends on stream_subarray_match port names
`default_nettype none

module ssm_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_stall,
    input wire logic        op,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        found,
    input wire logic [15:0] start_position
);

    // a stalled result transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(found) && $stable(start_position))
        else $error("result changed while stalled");

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a waiting result");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> start_position == 16'd0)
        else $error("not-found result with nonzero position");

    // a pattern load never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !op && !result_valid |=> !result_valid)
        else $error("result after a pattern load");

endmodule

bind stream_subarray_match ssm_checker u_ssm_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .op             (op),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .found          (found),
    .start_position (start_position)
);

`default_nettype wire
